// ----- design/arm_pkg.sv -----
// shared types and constants of the address region mapper
package arm_pkg;

    localparam int MAX_REGIONS_DEF = 16;
    localparam int PAGE_W          = 48;
    localparam int ENTRY_W         = 2 * PAGE_W + 3 + 32 + 32 + 64;

    localparam logic [1:0] MODE_ANY   = 2'd0;
    localparam logic [1:0] MODE_AT    = 2'd1;
    localparam logic [1:0] MODE_UNMAP = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISALIGN = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOSPACE  = 2'd3;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_PAGES = 2'd1;
    localparam logic [1:0] CFG_SHIFT = 2'd2;

    localparam logic [4:0] SHIFT_RST = 5'd12;

    typedef struct packed {
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] npages;
        logic [4:0]        shift;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] addr;
        logic [47:0] len;
        logic [2:0]  prot;
        logic [31:0] flags;
        logic [31:0] fd;
        logic [63:0] offset;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0] start;
        logic [PAGE_W-1:0] pages;
        logic [2:0]        prot;
        logic [31:0]       flags;
        logic [31:0]       fd;
        logic [63:0]       offset;
    } t_entry;

    typedef struct packed {
        logic        is_release;
        logic [1:0]  status;
        logic [47:0] mapped_addr;
        logic [47:0] rel_addr;
        logic [47:0] rel_len;
        logic [2:0]  rel_prot;
        logic [31:0] rel_flags;
        logic [31:0] rel_fd;
        logic [63:0] rel_offset;
        logic        last;
    } t_rec;

endpackage

// ----- design/arm_ram.sv -----
// generic single write port ram with registered read
module arm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/arm_seq.sv -----
// request sequencer: table scans, cut planning and bank copy with insertion
module arm_seq #(
    parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF,
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  arm_pkg::t_req         i_req,
    input  arm_pkg::t_cfg         i_cfg,
    output logic [IW-1:0]         o_raddr,
    input  arm_pkg::t_entry       i_rdata0,
    input  arm_pkg::t_entry       i_rdata1,
    output logic [1:0]            o_we,
    output logic [IW-1:0]         o_waddr,
    output arm_pkg::t_entry       o_wdata,
    output logic                  o_valid,
    output arm_pkg::t_rec         o_rec
);
    localparam int PW = arm_pkg::PAGE_W;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int KW = $clog2(MAX_REGIONS + 2);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_EV   = 8'b0001_0000,
        S_WR   = 8'b0010_0000,
        S_TAIL = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state          r_state;
    arm_pkg::t_req   r_req;
    arm_pkg::t_entry r_ent;
    logic [PW:0]     r_pages;
    logic [PW-1:0]   r_pga;
    logic            r_mis;
    logic [PW-1:0]   r_a;
    logic [PW:0]     r_e;
    logic [PW:0]     r_cur;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    logic [CW-1:0]   r_count;
    logic [KW-1:0]   r_kept;
    logic            r_pass2;
    logic            r_ins;
    logic            r_ov;
    logic [2:0]      r_wq;
    logic            r_bank;
    logic            r_valid;
    arm_pkg::t_rec   r_rec;

    function automatic arm_pkg::t_rec status_rec(input logic [1:0] st,
                                                 input logic [47:0] maddr);
        arm_pkg::t_rec rec;
        rec             = '0;
        rec.status      = st;
        rec.mapped_addr = maddr;
        rec.last        = 1'b1;
        return rec;
    endfunction

    logic [PW:0]     wsum;
    logic [PW-1:0]   wend;
    logic [PW-1:0]   pmask;
    logic [PW:0]     e_chk;
    arm_pkg::t_entry ent;
    logic [PW:0]     t_rd;
    logic            ov;
    logic            lo;
    logic            hi;
    logic [PW-1:0]   lim;
    logic            fit;
    logic            fit_end;
    logic [PW-1:0]   rs;
    logic [PW:0]     re;
    logic [PW:0]     rlen;
    logic [PW:0]     t_ent;
    logic [KW-1:0]   need;
    logic [KW-1:0]   keep_add;
    logic [2:0]      wq_ev;
    logic [2:0]      pick;
    arm_pkg::t_entry new_ent;

    always_comb begin
        wsum     = {1'b0, i_cfg.base} + {1'b0, i_cfg.npages};
        wend     = wsum[PW] ? {PW{1'b1}} : wsum[PW-1:0];
        pmask    = (PW'(1) << i_cfg.shift) - PW'(1);
        e_chk    = {1'b0, r_pga} + r_pages;
        ent      = r_bank ? i_rdata1 : i_rdata0;
        t_rd     = {1'b0, ent.start} + {1'b0, ent.pages};
        ov       = !((t_rd <= {1'b0, r_a}) || ({1'b0, ent.start} >= r_e));
        lo       = ent.start < r_a;
        hi       = ov ? (t_rd > r_e) : !lo;
        lim      = (ent.start < wend) ? ent.start : wend;
        fit      = ({1'b0, lim} > r_cur) && (({1'b0, lim} - r_cur) >= r_pages);
        fit_end  = ({1'b0, wend} > r_cur) && (({1'b0, wend} - r_cur) >= r_pages);
        rs       = lo ? r_a : ent.start;
        re       = (t_rd > r_e) ? r_e : t_rd;
        rlen     = re - {1'b0, rs};
        t_ent    = {1'b0, r_ent.start} + {1'b0, r_ent.pages};
        need     = r_kept + KW'(r_req.mode == arm_pkg::MODE_AT);
        keep_add = ov ? (KW'(lo) + KW'(t_rd > r_e)) : KW'(1);
        wq_ev    = {hi, hi & r_ins, lo};
        pick     = r_wq & (~r_wq + 3'd1);
        new_ent.start  = r_a;
        new_ent.pages  = r_pages[PW-1:0];
        new_ent.prot   = r_req.prot;
        new_ent.flags  = r_req.flags;
        new_ent.fd     = r_req.fd;
        new_ent.offset = r_req.offset;
    end

    always_comb begin
        o_raddr = r_i[IW-1:0];
        o_waddr = r_j[IW-1:0];
        o_wdata = r_ent;
        o_we    = 2'b00;
        if (r_state == S_WR && r_wq != 3'b000) begin
            o_we = r_bank ? 2'b01 : 2'b10;
            if (pick[0]) begin
                o_wdata.pages = r_ov ? (r_a - r_ent.start) : r_ent.pages;
            end else if (pick[1]) begin
                o_wdata = new_ent;
            end else begin
                o_wdata.start = r_ov ? r_e[PW-1:0] : r_ent.start;
                o_wdata.pages = r_ov ? PW'(t_ent - r_e) : r_ent.pages;
            end
        end else if (r_state == S_TAIL) begin
            o_we    = r_bank ? 2'b01 : 2'b10;
            o_wdata = new_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_bank  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_pages <= {1'b0, r_req.len >> i_cfg.shift}
                             + (PW+1)'(|(r_req.len & pmask));
                    r_pga   <= r_req.addr >> i_cfg.shift;
                    r_mis   <= |(r_req.addr & pmask);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_i     <= '0;
                    r_j     <= '0;
                    r_kept  <= '0;
                    r_pass2 <= 1'b0;
                    r_cur   <= {1'b0, i_cfg.base};
                    r_a     <= r_pga;
                    r_e     <= e_chk;
                    r_state <= S_IDLE;
                    if (r_req.mode == arm_pkg::MODE_NONE || r_pages == '0) begin
                        r_valid <= 1'b1;
                        r_rec   <= status_rec(arm_pkg::ST_RANGE, '0);
                    end else if (r_req.mode == arm_pkg::MODE_ANY) begin
                        if (r_count >= CW'(MAX_REGIONS)) begin
                            r_valid <= 1'b1;
                            r_rec   <= status_rec(arm_pkg::ST_NOSPACE, '0);
                        end else begin
                            r_state <= S_RD;
                        end
                    end else if (r_mis) begin
                        r_valid <= 1'b1;
                        r_rec   <= status_rec(arm_pkg::ST_MISALIGN, '0);
                    end else if (r_pga < i_cfg.base || e_chk > {1'b0, wend}) begin
                        r_valid <= 1'b1;
                        r_rec   <= status_rec(arm_pkg::ST_RANGE, '0);
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_i < r_count) begin
                        r_state <= S_EV;
                    end else if (r_pass2) begin
                        r_state <= r_ins ? S_TAIL : S_DONE;
                    end else if (r_req.mode == arm_pkg::MODE_ANY) begin
                        if (fit_end) begin
                            r_a     <= r_cur[PW-1:0];
                            r_e     <= r_cur + r_pages;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_pass2 <= 1'b1;
                            r_ins   <= 1'b1;
                        end else begin
                            r_valid <= 1'b1;
                            r_rec   <= status_rec(arm_pkg::ST_NOSPACE, '0);
                            r_state <= S_IDLE;
                        end
                    end else if (need > KW'(MAX_REGIONS)) begin
                        r_valid <= 1'b1;
                        r_rec   <= status_rec(arm_pkg::ST_NOSPACE, '0);
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_pass2 <= 1'b1;
                        r_ins   <= (r_req.mode != arm_pkg::MODE_UNMAP);
                    end
                end
                S_EV: begin
                    r_ent   <= ent;
                    r_ov    <= ov;
                    r_i     <= r_i + CW'(1);
                    r_state <= S_RD;
                    if (r_pass2) begin
                        r_wq <= wq_ev;
                        if (hi) begin
                            r_ins <= 1'b0;
                        end
                        if (wq_ev != 3'b000) begin
                            r_state <= S_WR;
                        end
                        if (ov) begin
                            r_valid            <= 1'b1;
                            r_rec              <= '0;
                            r_rec.is_release   <= 1'b1;
                            r_rec.rel_addr     <= rs << i_cfg.shift;
                            r_rec.rel_len      <= PW'(rlen) << i_cfg.shift;
                            r_rec.rel_prot     <= ent.prot;
                            r_rec.rel_flags    <= ent.flags;
                            r_rec.rel_fd       <= ent.fd;
                            r_rec.rel_offset   <= ent.offset;
                        end
                    end else if (r_req.mode == arm_pkg::MODE_ANY) begin
                        if (fit) begin
                            r_a     <= r_cur[PW-1:0];
                            r_e     <= r_cur + r_pages;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_pass2 <= 1'b1;
                            r_ins   <= 1'b1;
                        end else if (t_rd > r_cur) begin
                            r_cur <= t_rd;
                        end
                    end else begin
                        r_kept <= r_kept + keep_add;
                    end
                end
                S_WR: begin
                    r_wq <= r_wq & ~pick;
                    r_j  <= r_j + CW'(1);
                    if ((r_wq & ~pick) == 3'b000) begin
                        r_state <= S_RD;
                    end
                end
                S_TAIL: begin
                    r_j     <= r_j + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_bank  <= ~r_bank;
                    r_count <= r_j;
                    r_valid <= 1'b1;
                    r_rec   <= status_rec(arm_pkg::ST_OK,
                               (r_req.mode == arm_pkg::MODE_UNMAP) ? 48'd0
                                                              : (r_a << i_cfg.shift));
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REGIONS))
        else $error("region count above table depth");
    a_one_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we != 2'b11)
        else $error("both banks written at once");
    a_wr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we != 2'b00 |-> r_j < CW'(MAX_REGIONS))
        else $error("write past table depth");
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> o_valid && o_rec.last && !o_busy)
        else $error("commit without final status");
`endif
endmodule

// ----- design/address_region_mapper.sv -----
// address region mapper: first-fit page region table over a managed window
// a request rejected on its fields is answered from the check state; otherwise a check scan reads
// the entries, then a copy scan reads them again and writes kept pieces and any new region to the other bank
// throughput: one request at a time; busy stays high until the final status
// results are strobed on o_valid for one cycle each; the receiver cannot stall
// reset clears the table count, bank select and sequencer; window registers reset
module address_region_mapper #(
    parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [47:0]        i_byte_addr,
    input  logic [47:0]        i_byte_length,
    input  logic [2:0]         i_prot_bits,
    input  logic [31:0]        i_map_flags,
    input  logic signed [31:0] i_file_handle,
    input  logic signed [63:0] i_file_offset,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_is_release,
    output logic [1:0]         o_status,
    output logic [47:0]        o_mapped_addr,
    output logic [47:0]        o_released_addr,
    output logic [47:0]        o_released_len,
    output logic [2:0]         o_released_prot,
    output logic [31:0]        o_released_flags,
    output logic signed [31:0] o_released_fd,
    output logic signed [63:0] o_released_offset,
    output logic               o_last
);
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    arm_pkg::t_cfg   r_cfg;
    arm_pkg::t_req   req;
    arm_pkg::t_rec   rec;
    arm_pkg::t_entry rdata0;
    arm_pkg::t_entry rdata1;
    arm_pkg::t_entry wdata;
    logic [1:0]      we;
    logic [IW-1:0]   raddr;
    logic [IW-1:0]   waddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base   <= '0;
            r_cfg.npages <= '0;
            r_cfg.shift  <= arm_pkg::SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arm_pkg::CFG_BASE:  r_cfg.base   <= i_cfg_data;
                arm_pkg::CFG_PAGES: r_cfg.npages <= i_cfg_data;
                arm_pkg::CFG_SHIFT: r_cfg.shift  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign req = '{mode: i_mode, addr: i_byte_addr, len: i_byte_length,
                   prot: i_prot_bits, flags: i_map_flags, fd: i_file_handle,
                   offset: i_file_offset};

    arm_ram #(.WIDTH(arm_pkg::ENTRY_W), .DEPTH(MAX_REGIONS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we[0]),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata0)
    );

    arm_ram #(.WIDTH(arm_pkg::ENTRY_W), .DEPTH(MAX_REGIONS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we[1]),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata1)
    );

    arm_seq #(.MAX_REGIONS(MAX_REGIONS)) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_req    (req),
        .i_cfg    (r_cfg),
        .o_raddr  (raddr),
        .i_rdata0 (rdata0),
        .i_rdata1 (rdata1),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_valid  (o_valid),
        .o_rec    (rec)
    );

    assign o_is_release      = rec.is_release;
    assign o_status          = rec.status;
    assign o_mapped_addr     = rec.mapped_addr;
    assign o_released_addr   = rec.rel_addr;
    assign o_released_len    = rec.rel_len;
    assign o_released_prot   = rec.rel_prot;
    assign o_released_flags  = rec.rel_flags;
    assign o_released_fd     = rec.rel_fd;
    assign o_released_offset = rec.rel_offset;
    assign o_last            = rec.last;
endmodule
